FILE: hdl/assert_macros.svh
// Assertion macros shared by the census matching cost design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHM_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define CHM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define CHM_ASSERT_IMPLY(label, ante, cons)
`define CHM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hdl/chm_pkg.sv
// Types and constants of the census Hamming matching cost block
package chm_pkg;

    localparam int WORD_W = 64;
    localparam int DISP_W = 6;
    localparam int COST_W = 7;
    localparam int CNT_W  = 12;
    localparam int SIZE_W = 13;
    localparam int NDREG_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [COST_W-1:0] OUT_OF_ROW_COST = 7'd62;

    localparam logic [SIZE_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [SIZE_W-1:0]  RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [NDREG_W-1:0] RST_DISP_COUNT   = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_COUNT   = 2'd2;

    typedef struct packed {
        logic accept;
        logic issue;
        logic busy;
    } ctl_cmd_t;

    typedef struct packed {
        logic advance;
        logic last_issue;
    } ctl_sts_t;

endpackage

FILE: hdl/chm_ctrl.sv
// Controller state machine sequencing accept and disparity issue
module chm_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  chm_pkg::ctl_sts_t sts,
    output chm_pkg::ctl_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_ISSUE = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.busy  = 1'b1;
                cmd.issue = sts.advance;
                if (sts.advance && sts.last_issue)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/chm_dpath.sv
// Datapath: registers, counters, right word history, Hamming cost pipeline
module chm_dpath
#(
    parameter int MAX_DISPARITY = 64,
    parameter int MAX_WIDTH     = 4096
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  chm_pkg::ctl_cmd_t                   cmd,
    output chm_pkg::ctl_sts_t                   sts,
    input  logic                                cfg_valid,
    input  logic [chm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [chm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [chm_pkg::WORD_W-1:0]          left_census,
    input  logic [chm_pkg::WORD_W-1:0]          right_census,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [chm_pkg::DISP_W-1:0]          disparity,
    output logic [chm_pkg::COST_W-1:0]          cost,
    output logic                                last_of_pixel,
    output logic                                last_of_frame
);

    localparam int AW    = (MAX_DISPARITY > 1) ? $clog2(MAX_DISPARITY) : 1;
    localparam int DEPTH = 1 << AW;

    function automatic logic [3:0] byte_ones(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 4'(b[i]);
        end
        return n;
    endfunction

    function automatic logic [chm_pkg::COST_W-1:0] word_ones(
        input logic [chm_pkg::WORD_W-1:0] w);
        logic [chm_pkg::COST_W-1:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 7'(byte_ones(w[8*i +: 8]));
        end
        return n;
    endfunction

    logic [chm_pkg::SIZE_W-1:0]  width_reg;
    logic [chm_pkg::SIZE_W-1:0]  height_reg;
    logic [chm_pkg::NDREG_W-1:0] dcount_reg;

    logic [chm_pkg::CNT_W-1:0] col_reg;
    logic [chm_pkg::CNT_W-1:0] row_reg;

    logic [AW-1:0]                wp_reg;
    logic [chm_pkg::WORD_W-1:0]   hist_mem [DEPTH];
    logic [chm_pkg::WORD_W-1:0]   rd_reg;

    logic [chm_pkg::WORD_W-1:0]   left_reg;
    logic [chm_pkg::CNT_W-1:0]    pcol_reg;
    logic [chm_pkg::DISP_W-1:0]   ndm1_reg;
    logic                         fend_reg;
    logic [chm_pkg::DISP_W-1:0]   d_reg;

    logic                         s1_valid_reg;
    logic [chm_pkg::WORD_W-1:0]   s1_left_reg;
    logic [chm_pkg::DISP_W-1:0]   s1_d_reg;
    logic                         s1_oor_reg;
    logic                         s1_lastp_reg;
    logic                         s1_lastf_reg;

    logic                         out_valid_reg;
    logic [chm_pkg::DISP_W-1:0]   disp_reg;
    logic [chm_pkg::COST_W-1:0]   cost_reg;
    logic                         lastp_reg;
    logic                         lastf_reg;

    logic [chm_pkg::SIZE_W-1:0]  w_eff;
    logic [chm_pkg::SIZE_W-1:0]  h_eff;
    logic [chm_pkg::NDREG_W-1:0] nd_eff;
    logic                        row_end;
    logic                        frame_end;
    logic                        advance;
    logic [AW-1:0]               rd_addr;
    logic                        last_d;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = 13'd1;
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = chm_pkg::SIZE_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end

        if (height_reg == '0)
        begin
            h_eff = 13'd1;
        end
        else if (32'(height_reg) > 32'(MAX_WIDTH))
        begin
            h_eff = chm_pkg::SIZE_W'(MAX_WIDTH);
        end
        else
        begin
            h_eff = height_reg;
        end

        if (dcount_reg == '0)
        begin
            nd_eff = 7'd1;
        end
        else if (32'(dcount_reg) > 32'(MAX_DISPARITY))
        begin
            nd_eff = chm_pkg::NDREG_W'(MAX_DISPARITY);
        end
        else
        begin
            nd_eff = dcount_reg;
        end
    end

    assign row_end   = ({1'b0, col_reg} + 13'd1) >= w_eff;
    assign frame_end = row_end && (({1'b0, row_reg} + 13'd1) >= h_eff);

    assign advance = !out_valid_reg || !out_stall;
    assign last_d  = (d_reg == ndm1_reg);
    assign rd_addr = wp_reg - AW'(1) - d_reg[AW-1:0];

    assign sts.advance    = advance;
    assign sts.last_issue = last_d;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= chm_pkg::RST_IMAGE_WIDTH;
            height_reg <= chm_pkg::RST_IMAGE_HEIGHT;
            dcount_reg <= chm_pkg::RST_DISP_COUNT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                chm_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                chm_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                chm_pkg::CFG_DISP_COUNT:   dcount_reg <= cfg_data[chm_pkg::NDREG_W-1:0];
                default:                   ;
            endcase
        end
    end

    // position counters, history write pointer and disparity counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            wp_reg  <= '0;
            d_reg   <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                wp_reg <= wp_reg + AW'(1);
                d_reg  <= '0;
                if (row_end)
                begin
                    col_reg <= '0;
                    row_reg <= frame_end ? '0 : row_reg + 12'd1;
                end
                else
                begin
                    col_reg <= col_reg + 12'd1;
                end
            end
            else if (cmd.issue)
            begin
                d_reg <= d_reg + 6'd1;
            end
        end
    end

    // hold pixel context for the issue sequence
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            left_reg <= left_census;
            pcol_reg <= col_reg;
            ndm1_reg <= chm_pkg::DISP_W'(nd_eff - 7'd1);
            fend_reg <= frame_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            hist_mem[wp_reg] <= right_census;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_reg <= hist_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            s1_left_reg  <= left_reg;
            s1_d_reg     <= d_reg;
            s1_oor_reg   <= {{(chm_pkg::CNT_W-chm_pkg::DISP_W){1'b0}}, d_reg} > pcol_reg;
            s1_lastp_reg <= last_d;
            s1_lastf_reg <= last_d && fend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= cmd.issue;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            disp_reg  <= s1_d_reg;
            cost_reg  <= s1_oor_reg ? chm_pkg::OUT_OF_ROW_COST
                                    : word_ones(s1_left_reg ^ rd_reg);
            lastp_reg <= s1_lastp_reg;
            lastf_reg <= s1_lastf_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign disparity     = disp_reg;
    assign cost          = cost_reg;
    assign last_of_pixel = lastp_reg;
    assign last_of_frame = lastf_reg;

endmodule

FILE: hdl/census_hamming_matching_cost.sv
// Top level of the census Hamming matching cost block
//
// Input channel (in_valid, in_stall): one left/right census word pair per pixel,
// raster order. Output channel (out_valid, out_stall): one cost per disparity,
// disparity ascending from zero, last_of_pixel on the final one and
// last_of_frame on the final one of the frame's last pixel.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0
// image width, 1 image height, 2 disparity count; other indexes are dropped.
// Write it only while the block is idle.
// Each cost passes from the issue state through the stage-1 and output registers.
// Throughput: after the transfer in, the single history RAM read port serves one
// disparity per cycle while the output is not stalled.
// Stalling the output holds the pipeline; once all costs of the pixel are
// issued, the next pixel may transfer in while results still wait.
// Reset: registers return to 640 x 480 and 64 disparities, the position
// counters clear and the output stage empties.
module census_hamming_matching_cost
#(
    parameter int MAX_DISPARITY = 64,
    parameter int MAX_WIDTH     = 4096
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [chm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [chm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [chm_pkg::WORD_W-1:0]          left_census,
    input  logic [chm_pkg::WORD_W-1:0]          right_census,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [chm_pkg::DISP_W-1:0]          disparity,
    output logic [chm_pkg::COST_W-1:0]          cost,
    output logic                                last_of_pixel,
    output logic                                last_of_frame
);

    `include "assert_macros.svh"

    chm_pkg::ctl_cmd_t cmd;
    chm_pkg::ctl_sts_t sts;

    assign cfg_ready = 1'b1;
    assign in_stall  = cmd.busy;

    chm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    chm_dpath
    #(
        .MAX_DISPARITY (MAX_DISPARITY),
        .MAX_WIDTH     (MAX_WIDTH)
    )
    u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .left_census   (left_census),
        .right_census  (right_census),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .disparity     (disparity),
        .cost          (cost),
        .last_of_pixel (last_of_pixel),
        .last_of_frame (last_of_frame)
    );

    `CHM_ASSERT_IMPLY(a_frame_flag_on_pixel_end, out_valid && last_of_frame, last_of_pixel)
    `CHM_ASSERT_NEXT(a_busy_after_transfer, cmd.accept, in_stall)
    `CHM_ASSERT_NEXT(a_disparity_steps, out_valid && !out_stall && !last_of_pixel, out_valid && (disparity == $past(disparity) + 6'd1))

endmodule

FILE: bench/census_hamming_matching_cost_tb.sv
// Self-checking bench for the census Hamming matching cost block: random and directed pixels
module census_hamming_matching_cost_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DISP      = 64;
    localparam int MAX_SIZE      = 4096;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_PIXELS  = 20;

    localparam logic [chm_pkg::CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam logic [chm_pkg::WORD_W-1:0]    ALL_ONES        = {chm_pkg::WORD_W{1'b1}};

    typedef struct {
        logic [chm_pkg::WORD_W-1:0] left;
        logic [chm_pkg::WORD_W-1:0] right;
        bit                         drain_first;
    } census_pair_t;

    typedef struct packed {
        logic [chm_pkg::DISP_W-1:0] disparity;
        logic [chm_pkg::COST_W-1:0] cost;
        logic                       pixel_end;
        logic                       frame_end;
    } cost_result_t;

    logic                           clk;
    logic                           rst_n        = 1'b0;
    logic                           cfg_valid    = 1'b0;
    logic                           cfg_ready;
    logic [chm_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [chm_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
    logic                           in_valid     = 1'b0;
    logic                           in_stall;
    logic [chm_pkg::WORD_W-1:0]     left_census  = '0;
    logic [chm_pkg::WORD_W-1:0]     right_census = '0;
    logic                           out_valid;
    logic                           out_stall    = 1'b0;
    logic [chm_pkg::DISP_W-1:0]     disparity;
    logic [chm_pkg::COST_W-1:0]     cost;
    logic                           last_of_pixel;
    logic                           last_of_frame;

    census_pair_t pixel_q[$];
    cost_result_t cost_q[$];

    logic [chm_pkg::SIZE_W-1:0]  reg_width;
    logic [chm_pkg::SIZE_W-1:0]  reg_height;
    logic [chm_pkg::NDREG_W-1:0] reg_ndisp;
    logic [chm_pkg::WORD_W-1:0]  right_hist [0:MAX_DISP-1];
    int unsigned                 col_pos;
    int unsigned                 row_pos;

    bit in_accepted   = 1'b0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int cycle_count   = 0;

    census_hamming_matching_cost #(
        .MAX_DISPARITY (MAX_DISP),
        .MAX_WIDTH     (MAX_SIZE)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .left_census   (left_census),
        .right_census  (right_census),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .disparity     (disparity),
        .cost          (cost),
        .last_of_pixel (last_of_pixel),
        .last_of_frame (last_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned size_limit(input int unsigned v, input int unsigned hi);
        if (v == 0)
        begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [chm_pkg::COST_W-1:0] bit_count(
        input logic [chm_pkg::WORD_W-1:0] x);
        logic [chm_pkg::COST_W-1:0] n;
        int                         i;
        n = '0;
        for (i = 0; i < chm_pkg::WORD_W; i++)
        begin
            n += chm_pkg::COST_W'(x[i]);
        end
        return n;
    endfunction

    task automatic predict_costs(input logic [chm_pkg::WORD_W-1:0] l,
                                 input logic [chm_pkg::WORD_W-1:0] r);
        int unsigned                w;
        int unsigned                h;
        int unsigned                nd;
        int unsigned                d;
        bit                         row_end;
        bit                         frame_end;
        logic [chm_pkg::WORD_W-1:0] other;
        cost_result_t               res;
        w         = size_limit(reg_width, MAX_SIZE);
        h         = size_limit(reg_height, MAX_SIZE);
        nd        = size_limit(reg_ndisp, MAX_DISP);
        row_end   = (col_pos + 1) >= w;
        frame_end = row_end && ((row_pos + 1) >= h);
        for (d = 0; d < nd; d++)
        begin
            other         = (d == 0) ? r : right_hist[d - 1];
            res.disparity = chm_pkg::DISP_W'(d);
            res.cost      = (d > col_pos) ? chm_pkg::OUT_OF_ROW_COST : bit_count(l ^ other);
            res.pixel_end = (d + 1 == nd);
            res.frame_end = (d + 1 == nd) && frame_end;
            cost_q.push_back(res);
        end
        for (d = MAX_DISP - 1; d > 0; d--)
        begin
            right_hist[d] = right_hist[d - 1];
        end
        right_hist[0] = r;
        if (row_end)
        begin
            col_pos = 0;
            row_pos = frame_end ? 0 : ((row_pos + 1) & 12'hFFF);
        end
        else
        begin
            col_pos = (col_pos + 1) & 12'hFFF;
        end
    endtask

    function automatic void check_field(input string name,
                                        input logic [chm_pkg::COST_W-1:0] want,
                                        input logic [chm_pkg::COST_W-1:0] seen);
        if (seen !== want)
        begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, seen);
            error_count = error_count + 1;
        end
    endfunction

    // Driver: present pixels and drive the result stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
            if (!in_valid || in_accepted)
            begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct
                    && !(pixel_q[0].drain_first && cost_q.size() != 0))
                begin
                    in_valid     <= 1'b1;
                    left_census  <= pixel_q[0].left;
                    right_census <= pixel_q[0].right;
                    void'(pixel_q.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predict on each pixel transfer, check each cost transfer
    always @(posedge clk)
    begin : monitor
        cost_result_t want;
        if (rst_n)
        begin
            in_accepted <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (cost_q.size() == 0)
                begin
                    $display("%0t unexpected cost transfer: expected none %s %0d cost %0d",
                             $time, "actual disparity", disparity, cost);
                    error_count = error_count + 1;
                end
                else
                begin
                    want = cost_q.pop_front();
                    check_field("disparity", chm_pkg::COST_W'(want.disparity),
                                chm_pkg::COST_W'(disparity));
                    check_field("cost", want.cost, cost);
                    check_field("last_of_pixel", chm_pkg::COST_W'(want.pixel_end),
                                chm_pkg::COST_W'(last_of_pixel));
                    check_field("last_of_frame", chm_pkg::COST_W'(want.frame_end),
                                chm_pkg::COST_W'(last_of_frame));
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_costs(left_census, right_census);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL census_hamming_matching_cost");
            $finish;
        end
    end

    task automatic add_pixel(input logic [chm_pkg::WORD_W-1:0] l,
                             input logic [chm_pkg::WORD_W-1:0] r,
                             input bit drain_first);
        census_pair_t p;
        p.left        = l;
        p.right       = r;
        p.drain_first = drain_first;
        pixel_q.push_back(p);
    endtask

    task automatic write_reg(input logic [chm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [chm_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            chm_pkg::CFG_IMAGE_WIDTH:  reg_width  = val;
            chm_pkg::CFG_IMAGE_HEIGHT: reg_height = val;
            chm_pkg::CFG_DISP_COUNT:   reg_ndisp  = val[chm_pkg::NDREG_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        do @(posedge clk); while (pixel_q.size() != 0 || in_valid || cost_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(input int phase);
        case (phase / 5)
            0:
            begin
                send_idle_pct = 20;
                recv_idle_pct = 87;
            end
            1:
            begin
                send_idle_pct = 87;
                recv_idle_pct = 20;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    initial
    begin : stimulus
        int                         ph;
        int                         k;
        logic [chm_pkg::SIZE_W-1:0] w;
        logic [chm_pkg::SIZE_W-1:0] h;
        logic [chm_pkg::SIZE_W-1:0] nd;
        logic [chm_pkg::WORD_W-1:0] l;
        logic [chm_pkg::WORD_W-1:0] r;
        reg_width  = chm_pkg::RST_IMAGE_WIDTH;
        reg_height = chm_pkg::RST_IMAGE_HEIGHT;
        reg_ndisp  = chm_pkg::RST_DISP_COUNT;
        col_pos    = 0;
        row_pos    = 0;
        for (k = 0; k < MAX_DISP; k++)
        begin
            right_hist[k] = '0;
        end
        set_idling(0);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_pixel('0, '0, 1'b0);
        add_pixel(ALL_ONES, '0, 1'b0);
        add_pixel('0, ALL_ONES, 1'b0);
        add_pixel(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        add_pixel(ALL_ONES, ALL_ONES, 1'b0);
        add_pixel(64'h3FFF_FFFF_FFFF_FFFF, '0, 1'b0);
        settle();

        // shrink the row below the current column
        write_reg(chm_pkg::CFG_IMAGE_WIDTH, 13'd3);
        write_reg(chm_pkg::CFG_IMAGE_HEIGHT, 13'd2);
        write_reg(chm_pkg::CFG_DISP_COUNT, 13'd5);
        repeat (7) add_pixel({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        settle();

        write_reg(chm_pkg::CFG_IMAGE_WIDTH, '0);
        write_reg(chm_pkg::CFG_IMAGE_HEIGHT, '0);
        write_reg(chm_pkg::CFG_DISP_COUNT, '0);
        write_reg(CFG_SPARE_INDEX, 13'h1FFF);
        repeat (3) add_pixel({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        settle();

        write_reg(chm_pkg::CFG_IMAGE_WIDTH, 13'h1FFF);
        write_reg(chm_pkg::CFG_IMAGE_HEIGHT, 13'h1FFF);
        write_reg(chm_pkg::CFG_DISP_COUNT, 13'h1FFF);
        repeat (4) add_pixel({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        settle();

        for (ph = 4; ph < 4 + RANDOM_PHASES; ph++)
        begin
            set_idling(ph);
            case ($urandom_range(9))
                0:       w = '0;
                1:       w = 13'h1FFF;
                2:       w = 13'd4096;
                default: w = chm_pkg::SIZE_W'($urandom_range(40, 1));
            endcase
            case ($urandom_range(9))
                0:       h = '0;
                1:       h = 13'h1FFF;
                default: h = chm_pkg::SIZE_W'($urandom_range(5, 1));
            endcase
            case ($urandom_range(9))
                0:       nd = 13'd1;
                1:       nd = 13'd64;
                2:       nd = chm_pkg::SIZE_W'($urandom_range(8191, 65));
                default: nd = chm_pkg::SIZE_W'($urandom_range(64, 1));
            endcase
            write_reg(chm_pkg::CFG_IMAGE_WIDTH, w);
            write_reg(chm_pkg::CFG_IMAGE_HEIGHT, h);
            write_reg(chm_pkg::CFG_DISP_COUNT, nd);
            if ($urandom_range(3) == 0)
            begin
                write_reg(CFG_SPARE_INDEX, chm_pkg::CFG_DATA_W'($urandom));
            end
            for (k = 0; k < PHASE_PIXELS; k++)
            begin
                l = {$urandom, $urandom};
                case ($urandom_range(3))
                    0:       r = l ^ (64'd1 << $urandom_range(63));
                    1:       r = ~l;
                    default: r = {$urandom, $urandom};
                endcase
                add_pixel(l, r, $urandom_range(24) == 0);
            end
            settle();
        end

        if (error_count == 0 && cost_q.size() == 0)
        begin
            $display("PASS census_hamming_matching_cost");
        end
        else
        begin
            $display("FAIL census_hamming_matching_cost");
        end
        $finish;
    end

endmodule
